// ===== hdl/ictf_pkg.sv =====
// Shared types and constants for the IMU complementary tilt filter.
// Holds the port payload structs, the CORDIC vector type and the arctangent table.
// No dependencies.
package ictf_pkg;

    // CORDIC datapath widths: x/y carry the 16-bit samples plus gain growth,
    // z holds degrees with TABLE_FRAC fraction bits, up to about +/-190 degrees.
    localparam int XW         = 20;
    localparam int ZW         = 34;
    localparam int TABLE_FRAC = 24;
    localparam int TABLE_LEN  = 24;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [31:0] ATAN_Q24 [TABLE_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    typedef enum logic [1:0] {
        REG_GYRO_GAIN      = 2'd0,
        REG_BLEND_KEEP     = 2'd1,
        REG_MAGNITUDE_LOW  = 2'd2,
        REG_MAGNITUDE_HIGH = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic               accel_applied;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

endpackage

// ===== hdl/imu_complementary_tilt_filter_top.sv =====
// Top level of the IMU complementary tilt filter: control sequencer, gyro
// integration, blend arithmetic and the CORDIC cell chain. Depends on ictf_pkg
// and ictf_cordic_chain.
//
// Usage:
//  - sample channel (sample_valid/sample_stall/sample) carries one IMU beat:
//    three accel axes and two gyro axes. sample_stall is high while a beat is
//    being worked on; one beat is processed at a time.
//  - result channel (result_valid/result_stall/result) returns one beat per
//    sample: updated pitch, roll and the accel_applied flag.
//  - Without a blend a sample passes S_MUL, S_ADD and S_DONE; with the accel
//    correction blended in it passes S_MUL, S_ADD, S_CORDIC, S_BLEND_MUL,
//    S_BLEND_SUM and S_DONE (both atan2 vectors go down the same cell chain,
//    pitch vector first). The next sample is taken in the cycle after the
//    result is loaded.
//  - The result sits in an output register; a new sample is accepted while it
//    waits. If the receiver still stalls when the next result is ready, the
//    sequencer holds in its final state until the slot frees.
//  - Registers are written through wr_en/wr_index/wr_data, by the user only
//    while idle; the block does not enforce it. Reset clears both angle
//    estimates to zero, loads the default register values; no clearing pass.
module imu_complementary_tilt_filter_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ictf_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output ictf_pkg::result_t result,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [16:0]       wr_data
);

    localparam int XW        = ictf_pkg::XW;
    localparam int ZW        = ictf_pkg::ZW;
    localparam int ACC_SHIFT = ictf_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] ACC_HALF = $signed({{(ZW-1){1'b0}}, 1'b1} << (ACC_SHIFT-1));
    localparam logic signed [ZW-1:0] Z_90 = $signed({{(ZW-7){1'b0}}, 7'd90} << ictf_pkg::TABLE_FRAC);
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_MUL       = 7'b0000010,
        S_ADD       = 7'b0000100,
        S_CORDIC    = 7'b0001000,
        S_BLEND_MUL = 7'b0010000,
        S_BLEND_SUM = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    // Quadrant fold: x < 0 turns the point by +/-90 degrees first.
    function automatic ictf_pkg::vec_t prerotate(input logic signed [15:0] y,
                                                 input logic signed [15:0] x);
        ictf_pkg::vec_t     v;
        logic signed [XW-1:0] xe;
        logic signed [XW-1:0] ye;
        xe = {{(XW-16){x[15]}}, x};
        ye = {{(XW-16){y[15]}}, y};
        v.valid = 1'b1;
        if (!x[15])
        begin
            v.x = xe;
            v.y = ye;
            v.z = '0;
        end
        else if (!y[15])
        begin
            v.x = ye;
            v.y = -xe;
            v.z = Z_90;
        end
        else
        begin
            v.x = -ye;
            v.y = xe;
            v.z = -Z_90;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] round_acc(input logic signed [ZW-1:0] z,
                                                     input logic zero);
        logic signed [ZW-1:0] r;
        r = (z + ACC_HALF) >>> ACC_SHIFT;
        return zero ? 32'sd0 : r[31:0];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [15:0] gyro_gain_reg;
    logic [16:0] blend_keep_reg;
    logic [16:0] magnitude_low_reg;
    logic [16:0] magnitude_high_reg;

    ictf_pkg::sample_t  sample_reg;
    logic               applied_reg;
    logic               got_pitch_reg;
    logic signed [31:0] pitch_reg;
    logic signed [31:0] roll_reg;
    logic signed [32:0] prod_p_reg;
    logic signed [32:0] prod_r_reg;
    logic signed [31:0] pitch_acc_reg;
    logic signed [31:0] roll_acc_reg;
    logic signed [49:0] pk_reg;
    logic signed [49:0] pa_reg;
    logic signed [49:0] rk_reg;
    logic signed [49:0] ra_reg;

    ictf_pkg::result_t result_reg;
    logic              result_valid_reg;

    logic               accept;
    logic               out_free;
    logic [17:0]        magnitude;
    logic               applied_now;
    logic [16:0]        keep;
    logic [16:0]        rest;
    logic signed [16:0] gain_s;
    logic               pitch_zero;
    logic               roll_zero;
    ictf_pkg::vec_t     chain_in;
    ictf_pkg::vec_t     chain_out;

    assign accept   = sample_valid && !sample_stall;
    assign out_free = !result_valid_reg || !result_stall;

    assign magnitude = {1'b0, abs16(sample.accel_x)} + {1'b0, abs16(sample.accel_y)}
                     + {1'b0, abs16(sample.accel_z)};
    assign applied_now = (magnitude > {1'b0, magnitude_low_reg})
                      && (magnitude < {1'b0, magnitude_high_reg});

    assign keep   = (blend_keep_reg > ONE_Q16) ? ONE_Q16 : blend_keep_reg;
    assign rest   = ONE_Q16 - keep;
    assign gain_s = $signed({1'b0, gyro_gain_reg});

    assign pitch_zero = (sample_reg.accel_y == 16'sd0) && (sample_reg.accel_z == 16'sd0);
    assign roll_zero  = (sample_reg.accel_x == 16'sd0) && (sample_reg.accel_z == 16'sd0);

    // pitch vector enters in S_MUL, roll vector in the following S_ADD
    always_comb
    begin
        if (state_reg == S_MUL)
            chain_in = prerotate(sample_reg.accel_y, sample_reg.accel_z);
        else
            chain_in = prerotate(sample_reg.accel_x, sample_reg.accel_z);
        chain_in.valid = applied_reg && ((state_reg == S_MUL) || (state_reg == S_ADD));
    end

    ictf_cordic_chain #(
        .STEPS (CORDIC_STEPS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .vec_in  (chain_in),
        .vec_out (chain_out)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_ADD;
            S_ADD:
                state_next = applied_reg ? S_CORDIC : S_DONE;
            S_CORDIC:
                if (chain_out.valid && got_pitch_reg)
                    state_next = S_BLEND_MUL;
            S_BLEND_MUL:
                state_next = S_BLEND_SUM;
            S_BLEND_SUM:
                state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            gyro_gain_reg      <= 16'd10;
            blend_keep_reg     <= 17'd64225;
            magnitude_low_reg  <= 17'd8192;
            magnitude_high_reg <= 17'd32768;
            pitch_reg          <= '0;
            roll_reg           <= '0;
            applied_reg        <= 1'b0;
            got_pitch_reg      <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                case (ictf_pkg::reg_index_t'(wr_index))
                    ictf_pkg::REG_GYRO_GAIN:      gyro_gain_reg      <= wr_data[15:0];
                    ictf_pkg::REG_BLEND_KEEP:     blend_keep_reg     <= wr_data;
                    ictf_pkg::REG_MAGNITUDE_LOW:  magnitude_low_reg  <= wr_data;
                    ictf_pkg::REG_MAGNITUDE_HIGH: magnitude_high_reg <= wr_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                applied_reg   <= applied_now;
                got_pitch_reg <= 1'b0;
            end

            if (state_reg == S_ADD)
            begin
                pitch_reg <= sat32(64'(pitch_reg) + 64'(prod_p_reg));
                roll_reg  <= sat32(64'(roll_reg) - 64'(prod_r_reg));
            end

            if ((state_reg == S_CORDIC) && chain_out.valid)
                got_pitch_reg <= 1'b1;

            if (state_reg == S_BLEND_SUM)
            begin
                pitch_reg <= sat32((64'(pk_reg) + 64'(pa_reg) + 64'sd32768) >>> 16);
                roll_reg  <= sat32((64'(rk_reg) + 64'(ra_reg) + 64'sd32768) >>> 16);
            end

            if ((state_reg == S_DONE) && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= sample;

        if (state_reg == S_MUL)
        begin
            prod_p_reg <= 33'(sample_reg.gyro_x) * 33'(gain_s);
            prod_r_reg <= 33'(sample_reg.gyro_y) * 33'(gain_s);
        end

        if ((state_reg == S_CORDIC) && chain_out.valid)
        begin
            if (!got_pitch_reg)
                pitch_acc_reg <= round_acc(chain_out.z, pitch_zero);
            else
                roll_acc_reg <= round_acc(chain_out.z, roll_zero);
        end

        if (state_reg == S_BLEND_MUL)
        begin
            pk_reg <= 50'($signed({1'b0, keep})) * 50'(pitch_reg);
            pa_reg <= 50'($signed({1'b0, rest})) * 50'(pitch_acc_reg);
            rk_reg <= 50'($signed({1'b0, keep})) * 50'(roll_reg);
            ra_reg <= 50'($signed({1'b0, rest})) * 50'(roll_acc_reg);
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            result_reg.pitch_angle   <= pitch_reg;
            result_reg.roll_angle    <= roll_reg;
            result_reg.accel_applied <= applied_reg;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // chain only returns vectors while the sequencer waits for them
    a_chain_out_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == S_CORDIC))
        else $error("CORDIC chain output outside of the wait state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> sample_stall)
        else $error("sample accepted without going busy");

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (result_valid && (state_reg == S_IDLE)))
        else $error("result beat not loaded on completion");

    a_blend_only_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLEND_MUL) |-> (applied_reg && got_pitch_reg))
        else $error("blend entered without accel correction");

endmodule

// ===== hdl/ictf_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation, registered.
// Depends on ictf_pkg for the vector type and the arctangent table.
module ictf_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ictf_pkg::vec_t vec_in,
    output ictf_pkg::vec_t vec_out
);

    localparam logic signed [ictf_pkg::ZW-1:0] ANGLE =
        $signed({{(ictf_pkg::ZW-32){1'b0}}, ictf_pkg::ATAN_Q24[STEP]});

    logic signed [ictf_pkg::XW-1:0] xs;
    logic signed [ictf_pkg::XW-1:0] ys;
    ictf_pkg::vec_t                 vec_next;
    logic                           valid_reg;
    logic signed [ictf_pkg::XW-1:0] x_reg;
    logic signed [ictf_pkg::XW-1:0] y_reg;
    logic signed [ictf_pkg::ZW-1:0] z_reg;

    assign xs = vec_in.x >>> STEP;
    assign ys = vec_in.y >>> STEP;

    always_comb
    begin
        vec_next.valid = vec_in.valid;
        if (!vec_in.y[ictf_pkg::XW-1])
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + ANGLE;
        end
        else
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= vec_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= vec_next.x;
        y_reg <= vec_next.y;
        z_reg <= vec_next.z;
    end

    assign vec_out = {valid_reg, x_reg, y_reg, z_reg};

endmodule

// ===== hdl/ictf_cordic_chain.sv =====
// Row of CORDIC cells; a vector moves one cell per cycle.
// Depends on ictf_pkg and ictf_cordic_cell.
module ictf_cordic_chain #(
    parameter int STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ictf_pkg::vec_t vec_in,
    output ictf_pkg::vec_t vec_out
);

    ictf_pkg::vec_t stage [STEPS+1];

    assign stage[0] = vec_in;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        ictf_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vec_in  (stage[i]),
            .vec_out (stage[i+1])
        );
    end

    assign vec_out = stage[STEPS];

endmodule

// ===== bench/tilt_result_checker.sv =====
// Result checker for the IMU complementary tilt filter: tracks register writes,
// predicts pitch/roll per accepted sample beat and compares the result beats.
// Depends on ictf_pkg for the payload structs and register indexes.
module tilt_result_checker #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  ictf_pkg::sample_t sample,
    input  logic              result_valid,
    input  logic              result_stall,
    input  ictf_pkg::result_t result,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [16:0]       wr_data,
    output int                errors,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEG_FRAC = 24;

    // atan(2^-i) in degrees with 24 fraction bits
    localparam longint ATAN_DEG [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic [15:0]        gain_q;
    logic [16:0]        keep_q;
    logic [16:0]        low_q;
    logic [16:0]        high_q;
    logic signed [31:0] pitch_q;
    logic signed [31:0] roll_q;
    ictf_pkg::result_t  angle_queue [$];
    int                 taken;
    int                 retired;

    assign outstanding = taken - retired;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // vectoring CORDIC, result in degrees with ANGLE_FRAC_BITS fraction bits
    function automatic longint tilt_atan2(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t;
                z = longint'(90) << DEG_FRAC;
            end
            else
            begin
                t = x; x = -y; y = t;
                z = -(longint'(90) << DEG_FRAC);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + ATAN_DEG[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - ATAN_DEG[i];
            end
        end
        return (z + (longint'(1) << (DEG_FRAC - ANGLE_FRAC_BITS - 1)))
               >>> (DEG_FRAC - ANGLE_FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] blend_toward(logic signed [31:0] angle,
                                                        longint acc, longint keep);
        longint s;
        s = keep * longint'(angle) + (65536 - keep) * acc + 32768;
        return clamp32(s >>> 16);
    endfunction

    function automatic ictf_pkg::result_t advance_tilt(ictf_pkg::sample_t s);
        longint            ax;
        longint            ay;
        longint            az;
        longint            mag;
        longint            keep;
        longint            pitch_acc;
        longint            roll_acc;
        ictf_pkg::result_t r;
        ax = longint'($signed(s.accel_x));
        ay = longint'($signed(s.accel_y));
        az = longint'($signed(s.accel_z));
        pitch_q = clamp32(longint'(pitch_q) + longint'($signed(s.gyro_x)) * longint'(gain_q));
        roll_q  = clamp32(longint'(roll_q) - longint'($signed(s.gyro_y)) * longint'(gain_q));
        mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
        r.accel_applied = (mag > longint'(low_q)) && (mag < longint'(high_q));
        if (r.accel_applied)
        begin
            keep = (keep_q > 17'd65536) ? 65536 : longint'(keep_q);
            pitch_acc = tilt_atan2(ay, az);
            roll_acc  = tilt_atan2(ax, az);
            pitch_q = blend_toward(pitch_q, pitch_acc, keep);
            roll_q  = blend_toward(roll_q, roll_acc, keep);
        end
        r.pitch_angle = pitch_q;
        r.roll_angle  = roll_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ictf_pkg::result_t want;
        int                bad;
        if (!rst_n)
        begin
            gain_q  = 16'd10;
            keep_q  = 17'd64225;
            low_q   = 17'd8192;
            high_q  = 17'd32768;
            pitch_q = '0;
            roll_q  = '0;
            angle_queue.delete();
            errors  <= 0;
            taken   <= 0;
            retired <= 0;
        end
        else
        begin
            bad = 0;
            if (result_valid && !result_stall)
            begin
                if (angle_queue.size() == 0)
                begin
                    bad++;
                    $display("%0t: result beat with nothing expected: pitch %0d roll %0d",
                             $time, result.pitch_angle, result.roll_angle);
                end
                else
                begin
                    want = angle_queue.pop_front();
                    retired <= retired + 1;
                    if (result.pitch_angle !== want.pitch_angle)
                    begin
                        bad++;
                        $display("%0t: pitch_angle expected %0d, actual %0d",
                                 $time, want.pitch_angle, result.pitch_angle);
                    end
                    if (result.roll_angle !== want.roll_angle)
                    begin
                        bad++;
                        $display("%0t: roll_angle expected %0d, actual %0d",
                                 $time, want.roll_angle, result.roll_angle);
                    end
                    if (result.accel_applied !== want.accel_applied)
                    begin
                        bad++;
                        $display("%0t: accel_applied expected %0b, actual %0b",
                                 $time, want.accel_applied, result.accel_applied);
                    end
                end
            end
            if (sample_valid && !sample_stall)
            begin
                angle_queue.push_back(advance_tilt(sample));
                taken <= taken + 1;
            end
            if (wr_en)
            begin
                case (ictf_pkg::reg_index_t'(wr_index))
                    ictf_pkg::REG_GYRO_GAIN:      gain_q = wr_data[15:0];
                    ictf_pkg::REG_BLEND_KEEP:     keep_q = wr_data;
                    ictf_pkg::REG_MAGNITUDE_LOW:  low_q  = wr_data;
                    ictf_pkg::REG_MAGNITUDE_HIGH: high_q = wr_data;
                    default: ;
                endcase
            end
            errors <= errors + bad;
        end
    end

endmodule

// ===== bench/imu_complementary_tilt_filter_top_test.sv =====
// Testbench top for the IMU complementary tilt filter: clock, reset, register
// setup, sample stimulus and result-side stalls. Depends on ictf_pkg, the
// filter top level and tilt_result_checker.
module imu_complementary_tilt_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    ictf_pkg::sample_t sample_beat  = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    ictf_pkg::result_t result_beat;
    logic              wr_en        = 1'b0;
    logic [1:0]        wr_index     = '0;
    logic [16:0]       wr_data      = '0;
    int                errors;
    int                outstanding;
    int                sent         = 0;
    int                quiet_left   = 0;
    bit                hold_req     = 1'b0;

    imu_complementary_tilt_filter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    tilt_result_checker u_tilt_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1500000;
        $display("Verification failed");
        $finish;
    end

    function automatic ictf_pkg::sample_t mk(int ax, int ay, int az, int gx, int gy);
        ictf_pkg::sample_t s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.gyro_x  = 16'(gx);
        s.gyro_y  = 16'(gy);
        return s;
    endfunction

    function automatic logic [15:0] corner16();
        case ($urandom_range(0, 6))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            3:       return 16'h7FFF;
            4:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ictf_pkg::sample_t random_sample();
        ictf_pkg::sample_t s;
        int                k;
        k = $urandom_range(0, 99);
        if (k < 45)
        begin
            // moderate magnitudes, so the blend window is hit often
            s.accel_x = 16'(int'($urandom_range(0, 24000)) - 12000);
            s.accel_y = 16'(int'($urandom_range(0, 24000)) - 12000);
            s.accel_z = 16'(int'($urandom_range(0, 24000)) - 12000);
        end
        else if (k < 75)
        begin
            s.accel_x = 16'($urandom);
            s.accel_y = 16'($urandom);
            s.accel_z = 16'($urandom);
        end
        else
        begin
            s.accel_x = corner16();
            s.accel_y = corner16();
            s.accel_z = corner16();
        end
        if ($urandom_range(0, 99) < 70)
        begin
            s.gyro_x = 16'(int'($urandom_range(0, 4000)) - 2000);
            s.gyro_y = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
        else
        begin
            s.gyro_x = 16'($urandom);
            s.gyro_y = 16'($urandom);
        end
        return s;
    endfunction

    function automatic int sender_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // called and left at a rising edge; valid stays up when no gap follows
    task automatic send_sample(ictf_pkg::sample_t s);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_beat  <= s;
        do
            @(posedge clk);
        while (sample_stall);
        sent++;
        if (sent == 300)
            hold_req = 1'b1;
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic configure(logic [16:0] gain, logic [16:0] keep,
                             logic [16:0] lo, logic [16:0] hi);
        wr_en    <= 1'b1;
        wr_index <= ictf_pkg::REG_GYRO_GAIN;
        wr_data  <= gain;
        @(posedge clk);
        wr_index <= ictf_pkg::REG_BLEND_KEEP;
        wr_data  <= keep;
        @(posedge clk);
        wr_index <= ictf_pkg::REG_MAGNITUDE_LOW;
        wr_data  <= lo;
        @(posedge clk);
        wr_index <= ictf_pkg::REG_MAGNITUDE_HIGH;
        wr_data  <= hi;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, quiet stretches, and one long hold-off
    initial
    begin : receiver
        int r;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (200) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    result_stall <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge clk);
                end
                else if (r < 13)
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(8, 40)) @(posedge clk);
                end
                else
                begin
                    result_stall <= (r < 40);
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: window edges, zero vector, quadrant handling
        send_sample(mk(0, 0, 0, 0, 0));
        send_sample(mk(0, 16384, 0, 100, -100));
        send_sample(mk(10000, 0, -10000, 50, 50));
        send_sample(mk(-10000, -10000, -5000, -50, 20));
        send_sample(mk(5000, 5000, 10000, 0, 0));
        send_sample(mk(8192, 0, 0, 1, 1));
        send_sample(mk(16384, 16384, 0, -1, -1));
        send_sample(mk(0, 0, 8193, 7, -7));
        settle();

        // full gain and a kept angle: gyro saturation both ways
        configure(17'd65535, 17'd65536, 17'd0, 17'd98304);
        send_sample(mk(0, 0, 0, 32767, -32768));
        send_sample(mk(0, 0, 0, 32767, -32768));
        send_sample(mk(-32768, -32768, -32768, -32768, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768, 32767));
        send_sample(mk(-32768, -32768, 32767, 0, 0));
        settle();

        // angle fully replaced by the accelerometer angle
        configure(17'd1, 17'd0, 17'd0, 17'd98304);
        send_sample(mk(32767, -32768, -32768, 1, -1));
        send_sample(mk(-32768, 32767, 32767, -1, 1));
        send_sample(mk(1, -1, 0, 0, 0));
        send_sample(mk(-1, 0, 0, 0, 0));
        send_sample(mk(0, 1, -1, 0, 0));
        settle();

        // keep weight above one, gain with the unused top bit set
        configure(17'h1FFFF, 17'h1FFFF, 17'd0, 17'd98304);
        send_sample(mk(20000, 20000, 10000, 300, -300));
        send_sample(mk(10000, -20000, -20000, -300, 300));
        settle();

        // empty window
        configure(17'd5, 17'd32768, 17'd50000, 17'd50000);
        send_sample(mk(20000, 20000, 10000, 30, -30));
        send_sample(mk(25000, -25000, 0, -30, 30));
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            if ($urandom_range(0, 3) == 0)
                configure(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
                          17'($urandom_range(0, 98304)), 17'($urandom_range(0, 98304)));
            else
                configure(17'($urandom_range(1, 120)), 17'($urandom_range(58000, 65536)),
                          17'($urandom_range(0, 12000)), 17'($urandom_range(20000, 70000)));
            repeat (175) send_sample(random_sample());
            settle();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
